// ===== src/dfia_pkg.sv =====
// Package for the deferred free index allocator.
// Holds the default table size, the operation codes and the status codes.
// Used by the top level; depends on nothing.
package dfia_pkg;

  localparam int unsigned HEAP_SIZE_DEF = 2048;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

// ===== src/dfia_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot ring of the allocator; depends on nothing.
module dfia_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/deferred_free_index_allocator_unit.sv =====
// Deferred free index allocator: top level with ring control and result register.
// Depends on dfia_pkg and dfia_ram (slot ring storage).
// The result of an item appears in the cycle after it is accepted, marked by done.
// Throughput: one item per cycle; busy stays low, since each item makes one ring access.
// The ring read is registered in the RAM, so a reused index comes out with the result.
// Reset (synchronous, active high) clears pointers, counts, the bump counter and done at once.
module deferred_free_index_allocator_unit #(
  parameter int unsigned HEAP_SIZE = dfia_pkg::HEAP_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     func,
  input  logic [$clog2(HEAP_SIZE):0]     free_index,
  output logic                           done,
  output logic [$clog2(HEAP_SIZE)-1:0]   granted_index,
  output logic [1:0]                     status,
  output logic                           can_allocate
);
  import dfia_pkg::*;

  localparam int unsigned W = $clog2(HEAP_SIZE);
  localparam logic [W:0]   HEAP_CNT = (W + 1)'(HEAP_SIZE);
  localparam logic [W-1:0] LAST_PTR = W'(HEAP_SIZE - 1);

  logic [W-1:0] ready_head, ready_head_next;
  logic [W-1:0] ring_tail, ring_tail_next;
  logic [W:0]   ready_count, ready_count_next;
  logic [W:0]   pending_count, pending_count_next;
  logic [W:0]   fresh_next, fresh_next_next;

  logic [W-1:0] granted_q, granted_q_next;
  logic [1:0]   status_q, status_q_next;
  logic         can_q;
  logic         sel_ring, sel_ring_next;

  logic         accept;
  logic         ring_we;
  logic [W-1:0] ring_rdata;
  logic [W+1:0] occupied;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign occupied = {1'b0, ready_count} + {1'b0, pending_count};

  always_comb begin
    ready_head_next    = ready_head;
    ring_tail_next     = ring_tail;
    ready_count_next   = ready_count;
    pending_count_next = pending_count;
    fresh_next_next    = fresh_next;
    granted_q_next     = '0;
    status_q_next      = ST_OK;
    sel_ring_next      = 1'b0;
    ring_we            = 1'b0;
    if (accept) begin
      case (func)
        FUNC_ALLOC: begin
          if (ready_count != '0) begin
            // The ring entry at the head is read this edge and returned next cycle.
            sel_ring_next    = 1'b1;
            ready_head_next  = (ready_head == LAST_PTR) ? '0 : ready_head + 1'b1;
            ready_count_next = ready_count - 1'b1;
          end else if (fresh_next < HEAP_CNT) begin
            granted_q_next  = fresh_next[W-1:0];
            fresh_next_next = fresh_next + 1'b1;
          end else begin
            status_q_next = ST_EXHAUSTED;
          end
        end
        FUNC_FREE: begin
          if (free_index >= HEAP_CNT) begin
            status_q_next = ST_RANGE;
          end else if (occupied >= {1'b0, HEAP_CNT}) begin
            status_q_next = ST_FULL;
          end else begin
            ring_we            = 1'b1;
            ring_tail_next     = (ring_tail == LAST_PTR) ? '0 : ring_tail + 1'b1;
            pending_count_next = pending_count + 1'b1;
          end
        end
        FUNC_FRAME: begin
          ready_count_next   = occupied[W:0];
          pending_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_head    <= '0;
      ring_tail     <= '0;
      ready_count   <= '0;
      pending_count <= '0;
      fresh_next    <= '0;
      done          <= 1'b0;
    end else begin
      ready_head    <= ready_head_next;
      ring_tail     <= ring_tail_next;
      ready_count   <= ready_count_next;
      pending_count <= pending_count_next;
      fresh_next    <= fresh_next_next;
      done          <= accept;
    end
  end

  always_ff @(posedge clk) begin
    granted_q <= granted_q_next;
    status_q  <= status_q_next;
    sel_ring  <= sel_ring_next;
    can_q     <= (ready_count_next != '0) || (fresh_next_next < HEAP_CNT);
  end

  dfia_ram #(
    .WIDTH(W),
    .DEPTH(HEAP_SIZE)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_tail),
    .wdata(free_index[W-1:0]),
    .raddr(ready_head),
    .rdata(ring_rdata)
  );

  assign granted_index = sel_ring ? ring_rdata : granted_q;
  assign status        = status_q;
  assign can_allocate  = can_q;

`ifndef SYNTH
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupied <= {1'b0, HEAP_CNT})
    else $error("ring occupancy exceeds the table size");

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item produced no result");

  a_full_means_occupied: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupied == {1'b0, HEAP_CNT}))
    else $error("ring full reported while ring has room");

  a_ring_result_ok: assert property (@(posedge clk) disable iff (rst)
    sel_ring |-> (done && status == ST_OK))
    else $error("ring read returned outside a successful allocate");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= HEAP_CNT)
    else $error("bump counter ran past the table size");
`endif

endmodule

// ===== sim/deferred_free_index_allocator_unit_test.sv =====
// Self-checking testbench for deferred_free_index_allocator_unit.
// Each result is checked against an in-bench allocator state model; needs dfia_pkg
// and the block's RTL only.
module deferred_free_index_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfia_pkg::*;

  localparam int unsigned HEAP = HEAP_SIZE_DEF;
  localparam int IW = $clog2(HEAP);
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 500;

  typedef struct packed {
    logic [IW-1:0] index;
    logic [1:0]    status;
    logic          can;
  } grant_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [1:0]    func = FUNC_ALLOC;
  logic [IW:0]   free_index = '0;
  logic          busy;
  logic          done;
  logic [IW-1:0] granted_index;
  logic [1:0]    status;
  logic          can_allocate;

  deferred_free_index_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .free_index(free_index),
    .done(done),
    .granted_index(granted_index),
    .status(status),
    .can_allocate(can_allocate)
  );

  always #5 clk = ~clk;

  // Allocator state as the block should hold it.
  logic [IW-1:0] reuse_ring [HEAP];
  int unsigned   ready_ptr = 0;
  int unsigned   write_ptr = 0;
  int unsigned   ready_cnt = 0;
  int unsigned   pending_cnt = 0;
  int unsigned   fresh_next = 0;

  grant_t        expected_grants[$];
  logic [IW-1:0] granted_pool[$];
  int            mismatch_count = 0;
  int            gap_pct = 0;
  int            idle_cycles = 0;

  function grant_t predict_allocation(logic [1:0] f, logic [IW:0] idx);
    grant_t r;
    r = '0;
    r.status = ST_OK;
    case (f)
      FUNC_ALLOC: begin
        if (ready_cnt > 0) begin
          r.index = reuse_ring[ready_ptr];
          ready_ptr = (ready_ptr + 1) % HEAP;
          ready_cnt--;
        end else if (fresh_next < HEAP) begin
          r.index = IW'(fresh_next);
          fresh_next++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      FUNC_FREE: begin
        if (idx >= HEAP) begin
          r.status = ST_RANGE;
        end else if (ready_cnt + pending_cnt >= HEAP) begin
          r.status = ST_FULL;
        end else begin
          reuse_ring[write_ptr] = idx[IW-1:0];
          write_ptr = (write_ptr + 1) % HEAP;
          pending_cnt++;
        end
      end
      FUNC_FRAME: begin
        ready_cnt += pending_cnt;
        pending_cnt = 0;
      end
      default: ;
    endcase
    r.can = (ready_cnt > 0) || (fresh_next < HEAP);
    return r;
  endfunction

  // Leaves start high after acceptance so that back-to-back items need no toggle.
  // Each cycle the sender stays idle with a chance of gap_pct percent.
  task automatic send_item(logic [1:0] f, logic [IW:0] idx);
    grant_t r;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    free_index <= idx;
    do @(posedge clk); while (busy);
    r = predict_allocation(f, idx);
    expected_grants.push_back(r);
    if (f == FUNC_ALLOC && r.status == ST_OK) granted_pool.push_back(r.index);
  endtask

  function logic [IW:0] take_from_pool();
    int k;
    logic [IW-1:0] v;
    k = $urandom_range(granted_pool.size() - 1);
    v = granted_pool[k];
    granted_pool.delete(k);
    return {1'b0, v};
  endfunction

  function logic [IW:0] noise_index();
    return IW'($urandom_range(2 * HEAP - 1)) | ((IW + 1)'($urandom_range(1)) << IW);
  endfunction

  task automatic test_directed();
    send_item(FUNC_ALLOC, noise_index());
    send_item(FUNC_ALLOC, noise_index());
    send_item(FUNC_FREE, '0);
    send_item(FUNC_FREE, (IW + 1)'(HEAP - 1));
    send_item(FUNC_FREE, (IW + 1)'(HEAP));
    send_item(FUNC_FREE, '1);
    // Pending frees are not yet usable, so this comes from the bump counter.
    send_item(FUNC_ALLOC, '1);
    send_item(FUNC_SPARE, noise_index());
    send_item(FUNC_FRAME, noise_index());
    send_item(FUNC_ALLOC, noise_index());
    send_item(FUNC_ALLOC, noise_index());
    send_item(FUNC_ALLOC, noise_index());
    send_item(FUNC_FRAME, '1);
    send_item(FUNC_SPARE, '0);
    send_item(FUNC_FREE, {1'b0, {IW{1'b1}}});
    send_item(FUNC_FREE, (IW + 1)'(1));
    send_item(FUNC_FRAME, '0);
    send_item(FUNC_ALLOC, '0);
  endtask

  task automatic test_random(int count, int pct);
    int r;
    logic [IW:0] idx;
    gap_pct = pct;
    repeat (count) begin
      r = $urandom_range(99);
      idx = noise_index();
      if (r < 40) begin
        send_item(FUNC_ALLOC, idx);
      end else if (r < 75) begin
        r = $urandom_range(99);
        if (r < 80 && granted_pool.size() > 0) idx = take_from_pool();
        else if (r < 90) idx = (IW + 1)'($urandom_range(HEAP - 1));
        send_item(FUNC_FREE, idx);
      end else if (r < 93) begin
        send_item(FUNC_FRAME, idx);
      end else begin
        send_item(FUNC_SPARE, idx);
      end
    end
  endtask

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result: granted_index %0d status %0d can_allocate %0d",
                 $time, granted_index, status, can_allocate);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        check_field("granted_index", want.index, granted_index);
        check_field("status", want.status, status);
        check_field("can_allocate", want.can, can_allocate);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("deferred_free_index_allocator_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(135, 23);
    test_random(135, 62);
    test_random(135, 0);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("deferred_free_index_allocator_unit: match");
    end else begin
      $display("deferred_free_index_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
